// ===== design/sprs_pkg.sv =====
`timescale 1ns / 1ps

package sprs_pkg;

  localparam int PRIME_WIDTH_DEF = 32;
  localparam int FIELD_W         = 32;
  localparam int WIDE_W          = 64;
  localparam int WHEEL_W         = 16;
  localparam int SPAN_W          = 41;
  localparam int BOUND_W         = 33;
  localparam int ROOT_W          = 32;
  localparam int CFG_ADDR_W      = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_WHEEL_MODULUS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOWER_LIMIT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_SPAN    = 2'd2;

  typedef struct packed {
    logic [FIELD_W-1:0] prime;
    logic               action;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] root;
    logic [FIELD_W-1:0] lower_residue;
    logic               not_coprime;
  } out_item_t;

endpackage

// ===== design/sieve_prime_root_setup.sv =====
`timescale 1ns / 1ps

// Per-prime root and start-residue setup for a wheel sieve. One item is
// taken at a time: in_ready is high only while the sequencer is idle, and
// a finished result waits in the output register while the next item is
// taken. An item takes a square root on a restart and another when a
// linear prime moves the block forward, then (low bound + 1) mod prime
// and wheel_modulus mod prime on the shared bit-serial divider, then
// Euclid steps on the same divider, at most about 1.44 * PRIME_WIDTH of
// them. Prime zero or one skips the divider altogether.
module sieve_prime_root_setup #(
  parameter int PRIME_WIDTH = sprs_pkg::PRIME_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sprs_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sprs_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [sprs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sprs_pkg::WIDE_W-1:0]      cfg_data
);

  localparam int WW = sprs_pkg::WIDE_W;
  localparam int TW = PRIME_WIDTH + 3;
  localparam int FW = sprs_pkg::FIELD_W;

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b000000000001,
    ST_RSQ_WAIT = 12'b000000000010,
    ST_CHK      = 12'b000000000100,
    ST_ASQ_WAIT = 12'b000000001000,
    ST_RES      = 12'b000000010000,
    ST_RES_WAIT = 12'b000000100000,
    ST_AMOD     = 12'b000001000000,
    ST_AMOD_WT  = 12'b000010000000,
    ST_EUC      = 12'b000100000000,
    ST_EUC_WAIT = 12'b001000000000,
    ST_FIN      = 12'b010000000000,
    ST_SPARE    = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [sprs_pkg::WHEEL_W-1:0] wm_r;
  logic [WW-1:0]                ll_r;
  logic [sprs_pkg::SPAN_W-1:0]  span_r;

  // block tracking
  logic [WW-1:0]                 blo_r, blo_nxt;
  logic [WW-1:0]                 bhi_r, bhi_nxt;
  logic [sprs_pkg::BOUND_W-1:0]  bnd_r, bnd_nxt;

  // item and Euclid working set
  logic [PRIME_WIDTH-1:0] p_r, p_nxt;
  logic                   act_r, act_nxt;
  logic [PRIME_WIDTH-1:0] r0_r, r0_nxt, r1_r, r1_nxt;
  logic signed [TW-1:0]   t0_r, t0_nxt, t1_r, t1_nxt;
  logic [PRIME_WIDTH-1:0] resid_r, resid_nxt;
  logic [PRIME_WIDTH-1:0] root_r, root_nxt;
  logic                   nc_r, nc_nxt;

  // output slot
  logic                   out_valid_r, out_valid_nxt;
  sprs_pkg::out_item_t    out_r, out_nxt;

  // shared units
  logic                   div_start, div_long, div_done;
  logic [WW-1:0]          div_dvd;
  logic [PRIME_WIDTH-1:0] div_dsr, div_rem;
  logic signed [TW-1:0]   div_mul, div_prod;
  logic                   sq_start, sq_done;
  logic [WW-1:0]          sq_n;
  logic [sprs_pkg::ROOT_W-1:0] sq_root;

  logic [WW-1:0]          wm_ext;
  logic signed [TW-1:0]   inv_s;
  logic [PRIME_WIDTH-1:0] inv;

  sprs_div #(.PRIME_WIDTH(PRIME_WIDTH), .TW(TW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .long_mode(div_long),
    .dividend(div_dvd), .divisor(div_dsr), .mult(div_mul),
    .done(div_done), .rem(div_rem), .prod(div_prod)
  );

  sprs_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .n(sq_n),
    .done(sq_done), .root(sq_root)
  );

  assign wm_ext = WW'(wm_r);

  always_comb begin
    state_nxt     = state_r;
    blo_nxt       = blo_r;
    bhi_nxt       = bhi_r;
    bnd_nxt       = bnd_r;
    p_nxt         = p_r;
    act_nxt       = act_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    resid_nxt     = resid_r;
    root_nxt      = root_r;
    nc_nxt        = nc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    div_start     = 1'b0;
    div_long      = 1'b1;
    div_dvd       = '0;
    div_dsr       = p_r;
    div_mul       = '0;
    sq_start      = 1'b0;
    sq_n          = bhi_r + wm_ext;
    inv_s         = (t0_r < 0) ? (t0_r + $signed(TW'(p_r))) : t0_r;
    inv           = inv_s[PRIME_WIDTH-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          p_nxt   = in_item.prime[PRIME_WIDTH-1:0];
          act_nxt = in_item.action;
          if (in_item.restart) begin
            // reload tracking; the root is taken of block_high + modulus
            blo_nxt   = ll_r;
            bhi_nxt   = ll_r + WW'(span_r) - wm_ext;
            sq_n      = ll_r + WW'(span_r);
            sq_start  = 1'b1;
            state_nxt = ST_RSQ_WAIT;
          end else begin
            state_nxt = ST_CHK;
          end
        end
      end
      ST_RSQ_WAIT: begin
        if (sq_done) begin
          bnd_nxt   = sprs_pkg::BOUND_W'(sq_root) + sprs_pkg::BOUND_W'(1);
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (!act_r && (sprs_pkg::BOUND_W'(p_r) > bnd_r)) begin
          // advance the block once
          blo_nxt   = bhi_r + wm_ext;
          bhi_nxt   = bhi_r + WW'(span_r);
          sq_n      = bhi_r + WW'(span_r) + wm_ext;
          sq_start  = 1'b1;
          state_nxt = ST_ASQ_WAIT;
        end else begin
          state_nxt = ST_RES;
        end
      end
      ST_ASQ_WAIT: begin
        if (sq_done) begin
          bnd_nxt   = sprs_pkg::BOUND_W'(sq_root) + sprs_pkg::BOUND_W'(1);
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        if (p_r < PRIME_WIDTH'(2)) begin
          resid_nxt = '0;
          root_nxt  = '0;
          nc_nxt    = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          div_dvd   = (act_r ? ll_r : blo_r) + WW'(1);
          div_start = 1'b1;
          state_nxt = ST_RES_WAIT;
        end
      end
      ST_RES_WAIT: begin
        if (div_done) begin
          resid_nxt = div_rem;
          state_nxt = ST_AMOD;
        end
      end
      ST_AMOD: begin
        div_dvd   = wm_ext;
        div_start = 1'b1;
        state_nxt = ST_AMOD_WT;
      end
      ST_AMOD_WT: begin
        if (div_done) begin
          r0_nxt    = p_r;
          r1_nxt    = div_rem;
          t0_nxt    = '0;
          t1_nxt    = TW'(1);
          state_nxt = ST_EUC;
        end
      end
      ST_EUC: begin
        if (r1_r == '0) begin
          // gcd sits in r0; coefficient of the modulus in t0
          nc_nxt    = (r0_r != PRIME_WIDTH'(1));
          root_nxt  = (r0_r != PRIME_WIDTH'(1)) ? '0 : (p_r - inv);
          state_nxt = ST_FIN;
        end else begin
          div_long  = 1'b0;
          div_dvd   = WW'(r0_r);
          div_dsr   = r1_r;
          div_mul   = t1_r;
          div_start = 1'b1;
          state_nxt = ST_EUC_WAIT;
        end
      end
      ST_EUC_WAIT: begin
        if (div_done) begin
          r0_nxt    = r1_r;
          r1_nxt    = div_rem;
          t0_nxt    = t1_r;
          t1_nxt    = t0_r - div_prod;
          state_nxt = ST_EUC;
        end
      end
      ST_FIN: begin
        // hold until the output slot is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_nxt.root          = FW'(root_r);
          out_nxt.lower_residue = FW'(resid_r);
          out_nxt.not_coprime   = nc_r;
          state_nxt             = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      wm_r        <= sprs_pkg::WHEEL_W'(30);
      ll_r        <= '0;
      span_r      <= sprs_pkg::SPAN_W'(1048576);
      blo_r       <= '0;
      bhi_r       <= '0;
      bnd_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      blo_r       <= blo_nxt;
      bhi_r       <= bhi_nxt;
      bnd_r       <= bnd_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          sprs_pkg::REG_WHEEL_MODULUS: wm_r   <= cfg_data[sprs_pkg::WHEEL_W-1:0];
          sprs_pkg::REG_LOWER_LIMIT:   ll_r   <= cfg_data;
          sprs_pkg::REG_BLOCK_SPAN:    span_r <= cfg_data[sprs_pkg::SPAN_W-1:0];
          default: ;
        endcase
      end
    end
    p_r     <= p_nxt;
    act_r   <= act_nxt;
    r0_r    <= r0_nxt;
    r1_r    <= r1_nxt;
    t0_r    <= t0_nxt;
    t1_r    <= t1_nxt;
    resid_r <= resid_nxt;
    root_r  <= root_nxt;
    nc_r    <= nc_nxt;
    out_r   <= out_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== design/sprs_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit a cycle. While quotient bits appear
// MSB first, accumulate quotient * mult by shift-and-add.
module sprs_div #(
  parameter int PRIME_WIDTH = sprs_pkg::PRIME_WIDTH_DEF,
  parameter int TW          = PRIME_WIDTH + 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         long_mode,
  input  logic [sprs_pkg::WIDE_W-1:0]  dividend,
  input  logic [PRIME_WIDTH-1:0]       divisor,
  input  logic signed [TW-1:0]         mult,
  output logic                         done,
  output logic [PRIME_WIDTH-1:0]       rem,
  output logic signed [TW-1:0]         prod
);

  localparam int WW = sprs_pkg::WIDE_W;

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [6:0]             cnt_r, cnt_nxt;
  logic [WW-1:0]          dvd_r, dvd_nxt;
  logic [PRIME_WIDTH-1:0] dsr_r, dsr_nxt;
  logic [PRIME_WIDTH-1:0] rem_r, rem_nxt;
  logic signed [TW-1:0]   mul_r, mul_nxt;
  logic signed [TW-1:0]   prod_r, prod_nxt;
  logic [PRIME_WIDTH:0]   trial;
  logic                   qbit;

  always_comb begin
    trial    = {rem_r, dvd_r[WW-1]};
    qbit     = (trial >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    mul_nxt  = mul_r;
    prod_nxt = prod_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = long_mode ? 7'(WW) : 7'(PRIME_WIDTH);
      dvd_nxt  = long_mode ? dividend
                           : {dividend[PRIME_WIDTH-1:0], {(WW-PRIME_WIDTH){1'b0}}};
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      mul_nxt  = mult;
      prod_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = qbit ? PRIME_WIDTH'(trial - {1'b0, dsr_r}) : trial[PRIME_WIDTH-1:0];
      prod_nxt = (prod_r <<< 1) + (qbit ? mul_r : TW'(0));
      dvd_nxt  = {dvd_r[WW-2:0], 1'b0};
      cnt_nxt  = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r  <= dvd_nxt;
    dsr_r  <= dsr_nxt;
    rem_r  <= rem_nxt;
    mul_r  <= mul_nxt;
    prod_r <= prod_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;
  assign prod = prod_r;

endmodule

// ===== design/sprs_isqrt.sv =====
`timescale 1ns / 1ps

// Digit-by-digit integer square root of a 64-bit value.
module sprs_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sprs_pkg::WIDE_W-1:0]  n,
  output logic                         done,
  output logic [sprs_pkg::ROOT_W-1:0]  root
);

  localparam int WW = sprs_pkg::WIDE_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [WW-1:0] n_r, n_nxt;
  logic [WW-1:0] res_r, res_nxt;
  logic [WW-1:0] bit_r, bit_nxt;
  logic [WW-1:0] sum;

  always_comb begin
    sum      = res_r + bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    n_nxt    = n_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      n_nxt    = n;
      res_nxt  = '0;
      bit_nxt  = {2'b01, {(WW-2){1'b0}}};
    end else if (busy_r) begin
      if (n_r >= sum) begin
        n_nxt   = n_r - sum;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    n_r   <= n_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[sprs_pkg::ROOT_W-1:0];

endmodule

// ===== design/sprs_checker.sv =====
`timescale 1ns / 1ps

module sprs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sprs_pkg::out_item_t out_item
);

  // one item at a time: ready drops once an item is taken
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after an item was taken");

  // no result can appear the cycle after an item is taken
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared too early");

  a_flag_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.not_coprime == (out_item.root == '0)))
    else $error("root and not_coprime disagree");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind sieve_prime_root_setup sprs_checker u_sprs_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
);
